// ===== hw/rtl/tnps_pkg.sv =====
// ----------------------------------------------------------------------------
// tnps_pkg
// Shared constants for the two-nearest-point search unit: parameter defaults,
// field widths, register reset values, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tnps_pkg;

  // parameter defaults
  localparam int unsigned TableDepthDef = 128;
  localparam int unsigned CoordBitsDef  = 21;

  // fixed field widths
  localparam int unsigned IDX_BITS      = 7;
  localparam int unsigned DIST_BITS     = 43;
  localparam int unsigned ENTRIES_BITS  = 8;
  localparam int unsigned CUTOFF_BITS   = 22;
  localparam int unsigned CUT_SQ_BITS   = 2 * CUTOFF_BITS;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 22;

  // register reset values
  localparam logic [ENTRIES_BITS-1:0] ENTRIES_RESET = 8'd84;
  localparam logic [CUTOFF_BITS-1:0]  CUTOFF_RESET  = 22'd100000;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CUTOFF_DIST    = 2'd1;

endpackage

`default_nettype wire

// ===== hw/rtl/two_nearest_point_search_unit.sv =====
// ----------------------------------------------------------------------------
// two_nearest_point_search_unit
// Point table with a nearest / second-nearest search from a stored origin.
// Write: the point is stored at the input transfer. Query: after the origin
// entry read, one table entry is read per cycle into a 4-stage distance pipeline.
// Searched entries = min(entries_in_use, TABLE_DEPTH); a new item is taken only
// once the query's result is in the result register, also while that result waits.
// Reset restores entries_in_use = 84 and cutoff = 100000; the point table is
// not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
`default_nettype none

module two_nearest_point_search_unit #(
  parameter int unsigned TABLE_DEPTH = tnps_pkg::TableDepthDef,
  parameter int unsigned COORD_BITS  = tnps_pkg::CoordBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [tnps_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [tnps_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // input items
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                cmd_i,
  input  wire logic [tnps_pkg::IDX_BITS-1:0]       entry_index_i,
  input  wire logic [COORD_BITS-1:0]               point_lat_i,
  input  wire logic [COORD_BITS-1:0]               point_lon_i,
  // result items
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [tnps_pkg::IDX_BITS-1:0]            nearest_index_o,
  output logic                                     nearest_valid_o,
  output logic [tnps_pkg::IDX_BITS-1:0]            second_index_o,
  output logic                                     second_valid_o,
  output logic [tnps_pkg::DIST_BITS-1:0]           nearest_dist_sq_o
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW  = tnps_pkg::ENTRIES_BITS;
  localparam int unsigned SQW = 2 * COORD_BITS;
  localparam int unsigned DW  = (SQW + 1 > tnps_pkg::CUT_SQ_BITS) ?
                                SQW + 1 : tnps_pkg::CUT_SQ_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORIG,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [tnps_pkg::ENTRIES_BITS-1:0] entries_q;
  logic [tnps_pkg::CUTOFF_BITS-1:0]  cutoff_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= tnps_pkg::ENTRIES_RESET;
      cutoff_q  <= tnps_pkg::CUTOFF_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tnps_pkg::CFG_ENTRIES_IN_USE: entries_q <= cfg_data_i[tnps_pkg::ENTRIES_BITS-1:0];
        tnps_pkg::CFG_CUTOFF_DIST:    cutoff_q  <= cfg_data_i[tnps_pkg::CUTOFF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input transfer decode
  logic in_acc;
  logic origin_ok;
  logic [CW-1:0] lim_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign origin_ok  = (32'(entry_index_i) < 32'(TABLE_DEPTH));
  assign lim_d      = (32'(entries_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : entries_q;

  // scan control
  logic [CW-1:0]                  scan_cnt_q;
  logic [CW-1:0]                  lim_q;
  logic [tnps_pkg::IDX_BITS-1:0]  org_idx_q;
  logic                           issue;
  logic                           skip;

  assign issue = (state_q == ST_SCAN) && (scan_cnt_q != lim_q);
  assign skip  = (scan_cnt_q == CW'(org_idx_q));

  // point memory, one write and one registered read port
  logic [2*COORD_BITS-1:0] pt_mem_q [TABLE_DEPTH];
  logic [2*COORD_BITS-1:0] rd_data_q;
  logic                    mem_we;
  logic [AW-1:0]           rd_addr;

  assign mem_we  = in_acc && (cmd_i == tnps_pkg::CMD_WRITE) && origin_ok;
  assign rd_addr = (state_q == ST_SCAN) ? AW'(scan_cnt_q) : AW'(entry_index_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pt_mem_q[AW'(entry_index_i)] <= {point_lat_i, point_lon_i};
    end
    rd_data_q <= pt_mem_q[rd_addr];
  end

  // origin point and squared cutoff
  logic [COORD_BITS-1:0]            org_lat_q;
  logic [COORD_BITS-1:0]            org_lon_q;
  logic [tnps_pkg::CUT_SQ_BITS-1:0] cut_sq_q;

  // distance pipeline valids
  logic p1_v_q, p2_v_q, p3_v_q, p4_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
    end else begin
      p1_v_q <= issue && !skip;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
    end
  end

  // distance pipeline payload
  logic [CW-1:0]         p1_idx_q, p2_idx_q, p3_idx_q, p4_idx_q;
  logic [COORD_BITS-1:0] p2_dl_q, p2_dn_q;
  logic [SQW-1:0]        p3_sql_q, p3_sqn_q;
  logic [DW-1:0]         p4_d_q;
  logic                  p4_in_q;
  logic [COORD_BITS-1:0] e_lat, e_lon;
  logic [DW-1:0]         d_sum;

  assign e_lat = rd_data_q[2*COORD_BITS-1:COORD_BITS];
  assign e_lon = rd_data_q[COORD_BITS-1:0];
  assign d_sum = DW'(p3_sql_q) + DW'(p3_sqn_q);

  always_ff @(posedge clk_i) begin
    // stage 1: entry address
    p1_idx_q <= scan_cnt_q;
    // stage 2: absolute coordinate differences
    p2_idx_q <= p1_idx_q;
    p2_dl_q  <= (org_lat_q >= e_lat) ? org_lat_q - e_lat : e_lat - org_lat_q;
    p2_dn_q  <= (org_lon_q >= e_lon) ? org_lon_q - e_lon : e_lon - org_lon_q;
    // stage 3: squares
    p3_idx_q <= p2_idx_q;
    p3_sql_q <= SQW'(p2_dl_q) * SQW'(p2_dl_q);
    p3_sqn_q <= SQW'(p2_dn_q) * SQW'(p2_dn_q);
    // stage 4: sum and cutoff compare
    p4_idx_q <= p3_idx_q;
    p4_d_q   <= d_sum;
    p4_in_q  <= (d_sum < DW'(cut_sq_q));
  end

  // best and second-best tracking
  logic          best_v_q, second_v_q;
  logic [DW-1:0] best_d_q, second_d_q;
  logic [CW-1:0] best_i_q, second_i_q;
  logic          upd_first, upd_second, cand;

  assign cand       = p4_v_q && p4_in_q;
  assign upd_first  = !best_v_q || (p4_d_q < best_d_q);
  assign upd_second = !second_v_q || (p4_d_q < second_d_q);

  // saturated distance for the result
  logic [tnps_pkg::DIST_BITS-1:0] dist_sat;

  assign dist_sat = (best_d_q > DW'({tnps_pkg::DIST_BITS{1'b1}})) ?
                    {tnps_pkg::DIST_BITS{1'b1}} : best_d_q[tnps_pkg::DIST_BITS-1:0];

  // result register
  logic                           out_valid_q;
  logic [tnps_pkg::IDX_BITS-1:0]  nearest_index_q, second_index_q;
  logic                           nearest_valid_q, second_valid_q;
  logic [tnps_pkg::DIST_BITS-1:0] nearest_dist_q;

  // sequencer, tracking and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      scan_cnt_q      <= '0;
      lim_q           <= '0;
      org_idx_q       <= '0;
      org_lat_q       <= '0;
      org_lon_q       <= '0;
      cut_sq_q        <= '0;
      best_v_q        <= 1'b0;
      second_v_q      <= 1'b0;
      best_d_q        <= '0;
      second_d_q      <= '0;
      best_i_q        <= '0;
      second_i_q      <= '0;
      out_valid_q     <= 1'b0;
      nearest_index_q <= '0;
      second_index_q  <= '0;
      nearest_valid_q <= 1'b0;
      second_valid_q  <= 1'b0;
      nearest_dist_q  <= '0;
    end else begin
      // result transfer, unless a new result replaces it below
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      // fold in one candidate per cycle
      if (cand) begin
        if (upd_first) begin
          second_v_q <= best_v_q;
          second_d_q <= best_d_q;
          second_i_q <= best_i_q;
          best_v_q   <= 1'b1;
          best_d_q   <= p4_d_q;
          best_i_q   <= p4_idx_q;
        end else if (upd_second) begin
          second_v_q <= 1'b1;
          second_d_q <= p4_d_q;
          second_i_q <= p4_idx_q;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && (cmd_i == tnps_pkg::CMD_QUERY)) begin
            best_v_q   <= 1'b0;
            second_v_q <= 1'b0;
            best_d_q   <= '0;
            second_d_q <= '0;
            best_i_q   <= '0;
            second_i_q <= '0;
            lim_q      <= lim_d;
            org_idx_q  <= entry_index_i;
            cut_sq_q   <= tnps_pkg::CUT_SQ_BITS'(cutoff_q) *
                          tnps_pkg::CUT_SQ_BITS'(cutoff_q);
            state_q    <= origin_ok ? ST_ORIG : ST_DONE;
          end
        end
        ST_ORIG: begin
          org_lat_q  <= e_lat;
          org_lon_q  <= e_lon;
          scan_cnt_q <= '0;
          state_q    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (issue) begin
            scan_cnt_q <= scan_cnt_q + CW'(1);
          end else begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!(p1_v_q || p2_v_q || p3_v_q || p4_v_q)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q     <= 1'b1;
            nearest_index_q <= best_i_q[tnps_pkg::IDX_BITS-1:0];
            nearest_valid_q <= best_v_q;
            second_index_q  <= second_i_q[tnps_pkg::IDX_BITS-1:0];
            second_valid_q  <= second_v_q;
            nearest_dist_q  <= dist_sat;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign nearest_index_o   = nearest_index_q;
  assign nearest_valid_o   = nearest_valid_q;
  assign second_index_o    = second_index_q;
  assign second_valid_o    = second_valid_q;
  assign nearest_dist_sq_o = nearest_dist_q;

endmodule

`default_nettype wire
